// ===== rtl/core/per_key_sliding_window_rate_limiter_macros.svh =====
// Assertion macros used by the rate limiter controller.
`ifndef PER_KEY_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_KEY_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PKSWRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pkswrl: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PKSWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pkswrl: next-cycle check failed");

`endif

// ===== rtl/core/pkswrl_pkg.sv =====
// Package: sizes, register indexes and controller/datapath types of the rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package pkswrl_pkg;

	localparam int KEY_SLOTS   = 64;
	localparam int LOG_DEPTH   = 8;
	localparam int LOG_COUNT   = KEY_SLOTS * 2;
	localparam int LOG_W       = (LOG_COUNT > 1) ? $clog2(LOG_COUNT) : 1;
	localparam int HEAD_W      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int FILL_W      = $clog2(LOG_DEPTH + 1);
	localparam int SUM_W       = FILL_W + 1;
	localparam int MAXREQ_W    = 4;
	localparam int CNT_W       = (FILL_W > MAXREQ_W) ? FILL_W : MAXREQ_W;
	localparam int META_W      = HEAD_W + FILL_W;
	localparam int STAMP_DEPTH = LOG_COUNT * LOG_DEPTH;
	localparam int STAMP_AW    = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;

	localparam int KEY_W      = 6;
	localparam int STAMP_W    = 32;
	localparam int WIN_W      = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_START_MAX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_WIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_MAX   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_WIN   = 2'd3;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_END   = 1'b1;

	localparam logic [MAXREQ_W-1:0] MAX_RST = 4'd4;
	localparam logic [WIN_W-1:0]    WIN_RST = 31'd1000;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // take input word, start meta read
		logic meta_load;  // latch head/fill of the log
		logic peek;       // read oldest stamp
		logic pop;        // drop oldest stamp, read the next one
		logic commit;     // write back, append, load result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic key_bad;
		logic empty;
		logic expired;
		logic last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/core/per_key_sliding_window_rate_limiter.sv =====
// Requests are taken one at a time: a new request is accepted only after the last one commits.
// The expiry scan examines 0..8 stamps per request, one stamp per cycle, through
//   the single read port of the stamp memory; a refused bad key skips the scan.
// A finished result waits in the output register while the next word is accepted.
// Reset (arst_n low): all logs read as empty at once through per-log valid bits, no
//   clearing pass; limits reset to 4 and windows to 1000 ms.
`timescale 1ns / 1ps
`default_nettype none
module per_key_sliding_window_rate_limiter (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pkswrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pkswrl_pkg::CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pkswrl_pkg::KEY_W-1:0]      key_index,
	input  logic                              action_kind,
	input  logic [pkswrl_pkg::STAMP_W-1:0]    now_ms,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              allowed
);

	pkswrl_pkg::cmd_t    cmd;
	pkswrl_pkg::status_t status;

	// config registers take a word every cycle; writes must only come while idle (not enforced here)
	assign cfg_ready = 1'b1;

	// The controller walks each request with a good key through:
	//   accept -> read head/fill of log (key*2+action)
	//   -> scan oldest stamps, dropping those whose wrapping age >= window
	//   -> compare fill with the saturated limit, append now_ms if room
	//   -> write head/fill back and load the one-bit result.
	pkswrl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	// Datapath holds both memories: head/fill per log, and the stamp logs
	// (LOG_DEPTH entries per log), plus the output word register.
	pkswrl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.key_index  (key_index),
		.action_kind(action_kind),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.allowed    (allowed),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
`default_nettype wire

// ===== rtl/core/pkswrl_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pkswrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pkswrl_dp.sv =====
// Datapath: config registers, log metadata and stamp memories, expiry compare, result register.
`timescale 1ns / 1ps
`default_nettype none
module pkswrl_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [pkswrl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pkswrl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [pkswrl_pkg::KEY_W-1:0]         key_index,
	input  logic                                 action_kind,
	input  logic [pkswrl_pkg::STAMP_W-1:0]       now_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 allowed,
	input  pkswrl_pkg::cmd_t                     cmd,
	output pkswrl_pkg::status_t                  status
);

	logic [pkswrl_pkg::MAXREQ_W-1:0] start_max_q, end_max_q;
	logic [pkswrl_pkg::WIN_W-1:0]    start_win_q, end_win_q;

	logic [pkswrl_pkg::LOG_W-1:0]    log_in, log_q;
	logic [pkswrl_pkg::MAXREQ_W-1:0] max_in;
	logic [pkswrl_pkg::CNT_W-1:0]    lim_in, lim_q;
	logic [pkswrl_pkg::WIN_W-1:0]    win_q;
	logic [pkswrl_pkg::STAMP_W-1:0]  now_q;
	logic                            key_bad_q;

	logic [pkswrl_pkg::HEAD_W-1:0]   head_q, head_inc, slot;
	logic [pkswrl_pkg::FILL_W-1:0]   fill_q, fill_new;
	logic [pkswrl_pkg::SUM_W-1:0]    slot_sum;
	logic [pkswrl_pkg::LOG_COUNT-1:0] valid_q;

	logic [pkswrl_pkg::META_W-1:0]   meta_rdata;
	logic [pkswrl_pkg::HEAD_W-1:0]   meta_head;
	logic [pkswrl_pkg::FILL_W-1:0]   meta_fill;
	logic                            meta_we;

	logic [pkswrl_pkg::STAMP_AW-1:0] base, stamp_waddr, stamp_raddr;
	logic [pkswrl_pkg::STAMP_W-1:0]  stamp_rdata, age;
	logic                            stamp_we, stamp_re;
	logic                            full;
	logic                            out_valid_q, allowed_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_max_q <= pkswrl_pkg::MAX_RST;
			start_win_q <= pkswrl_pkg::WIN_RST;
			end_max_q   <= pkswrl_pkg::MAX_RST;
			end_win_q   <= pkswrl_pkg::WIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pkswrl_pkg::REG_START_MAX: start_max_q <= cfg_data[pkswrl_pkg::MAXREQ_W-1:0];
				pkswrl_pkg::REG_START_WIN: start_win_q <= cfg_data[pkswrl_pkg::WIN_W-1:0];
				pkswrl_pkg::REG_END_MAX:   end_max_q   <= cfg_data[pkswrl_pkg::MAXREQ_W-1:0];
				pkswrl_pkg::REG_END_WIN:   end_win_q   <= cfg_data[pkswrl_pkg::WIN_W-1:0];
			endcase
		end
	end

	// log number = key * 2 + action
	assign log_in = pkswrl_pkg::LOG_W'({key_index, action_kind});
	assign max_in = (action_kind == pkswrl_pkg::ACT_END) ? end_max_q : start_max_q;
	// limits above the log depth saturate to the depth
	assign lim_in = (pkswrl_pkg::CNT_W'(max_in) > pkswrl_pkg::CNT_W'(pkswrl_pkg::LOG_DEPTH)) ?
		pkswrl_pkg::CNT_W'(pkswrl_pkg::LOG_DEPTH) : pkswrl_pkg::CNT_W'(max_in);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			log_q     <= log_in;
			lim_q     <= lim_in;
			win_q     <= (action_kind == pkswrl_pkg::ACT_END) ? end_win_q : start_win_q;
			now_q     <= now_ms;
			key_bad_q <= (32'(key_index) >= pkswrl_pkg::KEY_SLOTS);
		end
	end

	// head/fill working copy
	assign meta_head = meta_rdata[pkswrl_pkg::META_W-1 -: pkswrl_pkg::HEAD_W];
	assign meta_fill = meta_rdata[pkswrl_pkg::FILL_W-1:0];
	assign head_inc  = (32'(head_q) == pkswrl_pkg::LOG_DEPTH - 1) ? '0 :
		head_q + pkswrl_pkg::HEAD_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.meta_load) begin
			// a log never written since reset reads as empty
			head_q <= valid_q[log_q] ? meta_head : '0;
			fill_q <= valid_q[log_q] ? meta_fill : '0;
		end else if (cmd.pop) begin
			head_q <= head_inc;
			fill_q <= fill_q - pkswrl_pkg::FILL_W'(1);
		end
	end

	assign full     = (pkswrl_pkg::CNT_W'(fill_q) >= lim_q);
	assign fill_new = full ? fill_q : fill_q + pkswrl_pkg::FILL_W'(1);
	assign meta_we  = cmd.commit && !key_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (meta_we) begin
			valid_q[log_q] <= 1'b1;
		end
	end

	pkswrl_ram #(
		.WIDTH(pkswrl_pkg::META_W),
		.DEPTH(pkswrl_pkg::LOG_COUNT)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(log_q),
		.wdata({head_q, fill_new}),
		.re   (cmd.accept),
		.raddr(log_in),
		.rdata(meta_rdata)
	);

	// append slot = (head + fill) mod depth, sum stays below twice the depth
	assign slot_sum = pkswrl_pkg::SUM_W'(head_q) + pkswrl_pkg::SUM_W'(fill_q);
	assign slot = (32'(slot_sum) >= pkswrl_pkg::LOG_DEPTH) ?
		pkswrl_pkg::HEAD_W'(slot_sum - pkswrl_pkg::SUM_W'(pkswrl_pkg::LOG_DEPTH)) :
		pkswrl_pkg::HEAD_W'(slot_sum);

	assign base        = pkswrl_pkg::STAMP_AW'(log_q) *
		pkswrl_pkg::STAMP_AW'(pkswrl_pkg::LOG_DEPTH);
	assign stamp_waddr = base + pkswrl_pkg::STAMP_AW'(slot);
	assign stamp_raddr = base + pkswrl_pkg::STAMP_AW'(cmd.pop ? head_inc : head_q);
	assign stamp_we    = cmd.commit && !key_bad_q && !full;
	assign stamp_re    = cmd.peek || cmd.pop;

	pkswrl_ram #(
		.WIDTH(pkswrl_pkg::STAMP_W),
		.DEPTH(pkswrl_pkg::STAMP_DEPTH)
	) u_stamp_ram (
		.clk  (clk),
		.we   (stamp_we),
		.waddr(stamp_waddr),
		.wdata(now_q),
		.re   (stamp_re),
		.raddr(stamp_raddr),
		.rdata(stamp_rdata)
	);

	// wrapping age against the window
	assign age = now_q - stamp_rdata;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			allowed_q <= !key_bad_q && !full;
		end
	end

	assign out_valid = out_valid_q;
	assign allowed   = allowed_q;

	assign status.key_bad  = key_bad_q;
	assign status.empty    = (fill_q == '0);
	assign status.expired  = (age >= {1'b0, win_q});
	assign status.last     = (fill_q == pkswrl_pkg::FILL_W'(1));
	assign status.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// ===== rtl/core/pkswrl_ctrl.sv =====
// Controller: sequences accept, metadata load, expiry scan and commit of one request.
`timescale 1ns / 1ps
`default_nettype none
`include "per_key_sliding_window_rate_limiter_macros.svh"
module pkswrl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pkswrl_pkg::status_t status,
	output pkswrl_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_META   = 3'd1;
	localparam logic [2:0] ST_PEEK   = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_META;
				end
			end
			ST_META: begin
				cmd.meta_load = 1'b1;
				state_d       = status.key_bad ? ST_DECIDE : ST_PEEK;
			end
			ST_PEEK: begin
				if (status.empty) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.peek = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// pop also fetches the next stamp so the scan runs one per cycle
				if (status.expired) begin
					cmd.pop = 1'b1;
					if (status.last) begin
						state_d = ST_DECIDE;
					end
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`PKSWRL_ASSERT_NEXT(a_accept_to_meta, clk, arst_n, in_valid && in_ready, state_q == ST_META)
	`PKSWRL_ASSERT_NOW(a_check_nonempty, clk, arst_n, state_q == ST_CHECK, !status.empty)
	`PKSWRL_ASSERT_NOW(a_pop_good_key, clk, arst_n, cmd.pop, !status.key_bad)
	`PKSWRL_ASSERT_NOW(a_cmd_exclusive, clk, arst_n, 1'b1, $onehot0(cmd))

endmodule
`default_nettype wire
